// ===== sv/gcsf_pkg.sv =====
// Shared types, codes and helpers for the glyph class skip filter.
`timescale 1ns / 1ps
`default_nettype none
package gcsf_pkg;

  localparam int ARRAY_DEPTH = 256;
  localparam int RANGE_DEPTH = 64;
  localparam int ARRAY_AW    = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
  localparam int RANGE_AW    = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;

  // Command codes of an input word.
  localparam logic [2:0] CMD_QUERY     = 3'd0;
  localparam logic [2:0] CMD_LOAD_GC_A = 3'd1;
  localparam logic [2:0] CMD_LOAD_GC_R = 3'd2;
  localparam logic [2:0] CMD_LOAD_MA_A = 3'd3;
  localparam logic [2:0] CMD_LOAD_MA_R = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_GC_FORMAT = 3'd0;
  localparam logic [2:0] REG_GC_START  = 3'd1;
  localparam logic [2:0] REG_GC_COUNT  = 3'd2;
  localparam logic [2:0] REG_GC_RCOUNT = 3'd3;
  localparam logic [2:0] REG_MA_FORMAT = 3'd4;
  localparam logic [2:0] REG_MA_START  = 3'd5;
  localparam logic [2:0] REG_MA_COUNT  = 3'd6;
  localparam logic [2:0] REG_MA_RCOUNT = 3'd7;

  // Table formats.
  localparam logic [1:0] FMT_NONE  = 2'd0;
  localparam logic [1:0] FMT_DENSE = 2'd1;
  localparam logic [1:0] FMT_RANGE = 2'd2;

  // Glyph class values.
  localparam logic [15:0] CLS_BASE      = 16'd1;
  localparam logic [15:0] CLS_LIGATURE  = 16'd2;
  localparam logic [15:0] CLS_MARK      = 16'd3;
  localparam logic [15:0] CLS_COMPONENT = 16'd4;

  // Property bit positions.
  localparam int PROP_BASE = 0;
  localparam int PROP_MARK = 1;
  localparam int PROP_LIG  = 2;
  localparam int PROP_COMP = 3;

  // Lookup flag bits.
  localparam int FLAG_IGNORE_BASE = 1;
  localparam int FLAG_IGNORE_LIG  = 2;
  localparam int FLAG_IGNORE_MARK = 3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  entry_index;
    logic [15:0] glyph_id;
    logic [15:0] range_first;
    logic [15:0] range_last;
    logic [15:0] class_value;
    logic [15:0] lookup_flag;
  } gcsf_item_t;

  typedef struct packed {
    logic skipped;
    logic is_base;
    logic is_mark;
    logic is_ligature;
    logic is_component;
  } gcsf_result_t;

  typedef struct packed {
    logic [15:0] first;
    logic [15:0] last;
    logic [15:0] cls;
  } gcsf_range_t;

  typedef struct packed {
    logic capture;
    logic issue;
    logic dense_take;
    logic finish;
    logic wr_gc_arr;
    logic wr_gc_rng;
    logic wr_ma_arr;
    logic wr_ma_rng;
  } gcsf_cmd_t;

  typedef struct packed {
    logic scan_end;
  } gcsf_status_t;

  function automatic logic [3:0] class_bits(input logic [15:0] cls);
    logic [3:0] bits;
    bits = 4'b0000;
    unique case (cls)
      CLS_BASE:      bits[PROP_BASE] = 1'b1;
      CLS_MARK:      bits[PROP_MARK] = 1'b1;
      CLS_LIGATURE:  bits[PROP_LIG]  = 1'b1;
      CLS_COMPONENT: bits[PROP_COMP] = 1'b1;
      default:       bits = 4'b0000;
    endcase
    return bits;
  endfunction

endpackage
`default_nettype wire

// ===== sv/gcsf_ctrl.sv =====
// Controller state machine: decodes words and sequences the range scan.
`timescale 1ns / 1ps
`default_nettype none
module gcsf_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [2:0]            cmd_code,
  input  wire gcsf_pkg::gcsf_status_t status,
  output gcsf_pkg::gcsf_cmd_t        ctl,
  output logic                       busy
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_LAST   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_code)
            gcsf_pkg::CMD_QUERY: begin
              ctl.capture = 1'b1;
              state_next  = S_SCAN;
            end
            gcsf_pkg::CMD_LOAD_GC_A: ctl.wr_gc_arr = 1'b1;
            gcsf_pkg::CMD_LOAD_GC_R: ctl.wr_gc_rng = 1'b1;
            gcsf_pkg::CMD_LOAD_MA_A: ctl.wr_ma_arr = 1'b1;
            gcsf_pkg::CMD_LOAD_MA_R: ctl.wr_ma_rng = 1'b1;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        ctl.issue = 1'b1;
        if (status.scan_end) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        ctl.dense_take = 1'b1;
        state_next     = S_FINISH;
      end
      S_FINISH: begin
        ctl.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  a_scan_leads_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && status.scan_end) |=> (state == S_LAST))
    else $error("scan end did not lead to the last-data state");

  a_last_then_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_LAST) |=> (state == S_FINISH))
    else $error("last-data state not followed by finish");

  a_query_starts_scan: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |=> (state == S_SCAN))
    else $error("query capture did not start a scan");

endmodule
`default_nettype wire

// ===== sv/gcsf_datapath.sv =====
// Datapath: configuration, table memories, range matchers and skip decision.
`timescale 1ns / 1ps
`default_nettype none
module gcsf_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire gcsf_pkg::gcsf_item_t  item,
  input  wire gcsf_pkg::gcsf_cmd_t   ctl,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [15:0]           cfg_data,
  output gcsf_pkg::gcsf_status_t     status,
  output gcsf_pkg::gcsf_result_t     result,
  output logic                       done
);

  // Configuration
  logic [1:0]  gc_format;
  logic [15:0] gc_start;
  logic [8:0]  gc_count;
  logic [6:0]  gc_rcount;
  logic [1:0]  ma_format;
  logic [15:0] ma_start;
  logic [8:0]  ma_count;
  logic [6:0]  ma_rcount;

  always_ff @(posedge clk) begin
    if (rst) begin
      gc_format <= '0;
      gc_start  <= '0;
      gc_count  <= '0;
      gc_rcount <= '0;
      ma_format <= '0;
      ma_start  <= '0;
      ma_count  <= '0;
      ma_rcount <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gcsf_pkg::REG_GC_FORMAT: gc_format <= cfg_data[1:0];
        gcsf_pkg::REG_GC_START:  gc_start  <= cfg_data;
        gcsf_pkg::REG_GC_COUNT:  gc_count  <= cfg_data[8:0];
        gcsf_pkg::REG_GC_RCOUNT: gc_rcount <= cfg_data[6:0];
        gcsf_pkg::REG_MA_FORMAT: ma_format <= cfg_data[1:0];
        gcsf_pkg::REG_MA_START:  ma_start  <= cfg_data;
        gcsf_pkg::REG_MA_COUNT:  ma_count  <= cfg_data[8:0];
        gcsf_pkg::REG_MA_RCOUNT: ma_rcount <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Table memories
  logic [15:0]           gc_arr [gcsf_pkg::ARRAY_DEPTH];
  logic [15:0]           ma_arr [gcsf_pkg::ARRAY_DEPTH];
  gcsf_pkg::gcsf_range_t gc_rng [gcsf_pkg::RANGE_DEPTH];
  gcsf_pkg::gcsf_range_t ma_rng [gcsf_pkg::RANGE_DEPTH];

  logic                          arr_slot_ok;
  logic                          rng_slot_ok;
  logic [gcsf_pkg::ARRAY_AW-1:0] arr_waddr;
  logic [gcsf_pkg::RANGE_AW-1:0] rng_waddr;
  gcsf_pkg::gcsf_range_t         rng_wdata;

  assign arr_slot_ok = (32'(item.entry_index) < gcsf_pkg::ARRAY_DEPTH);
  assign rng_slot_ok = (32'(item.entry_index) < gcsf_pkg::RANGE_DEPTH);
  assign arr_waddr   = gcsf_pkg::ARRAY_AW'(item.entry_index);
  assign rng_waddr   = gcsf_pkg::RANGE_AW'(item.entry_index);
  assign rng_wdata   = '{first: item.range_first, last: item.range_last,
                         cls: item.class_value};

  // Query registers and scan counter
  logic [15:0]                   glyph;
  logic [15:0]                   flag;
  logic [gcsf_pkg::RANGE_AW-1:0] idx;
  logic [gcsf_pkg::RANGE_AW-1:0] idx_d;
  logic                          rd_valid;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      glyph <= item.glyph_id;
      flag  <= item.lookup_flag;
    end
    if (ctl.issue) begin
      idx_d <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= ctl.issue;
      if (ctl.capture) begin
        idx <= '0;
      end else if (ctl.issue) begin
        idx <= idx + 1'b1;
      end
    end
  end

  assign status.scan_end =
    (idx == gcsf_pkg::RANGE_AW'(gcsf_pkg::RANGE_DEPTH - 1));

  // Dense lookup address and coverage
  logic [15:0] gc_off;
  logic [15:0] ma_off;
  logic        gc_cover;
  logic        ma_cover;

  assign gc_off   = glyph - gc_start;
  assign ma_off   = glyph - ma_start;
  assign gc_cover = (glyph >= gc_start) && (32'(gc_off) < 32'(gc_count)) &&
                    (32'(gc_off) < gcsf_pkg::ARRAY_DEPTH);
  assign ma_cover = (glyph >= ma_start) && (32'(ma_off) < 32'(ma_count)) &&
                    (32'(ma_off) < gcsf_pkg::ARRAY_DEPTH);

  logic [15:0]           gc_arr_q;
  logic [15:0]           ma_arr_q;
  gcsf_pkg::gcsf_range_t gc_rng_q;
  gcsf_pkg::gcsf_range_t ma_rng_q;

  always_ff @(posedge clk) begin
    if (ctl.wr_gc_arr && arr_slot_ok) begin
      gc_arr[arr_waddr] <= item.class_value;
    end
    gc_arr_q <= gc_arr[gcsf_pkg::ARRAY_AW'(gc_off)];
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_ma_arr && arr_slot_ok) begin
      ma_arr[arr_waddr] <= item.class_value;
    end
    ma_arr_q <= ma_arr[gcsf_pkg::ARRAY_AW'(ma_off)];
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_gc_rng && rng_slot_ok) begin
      gc_rng[rng_waddr] <= rng_wdata;
    end
    if (ctl.issue) begin
      gc_rng_q <= gc_rng[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_ma_rng && rng_slot_ok) begin
      ma_rng[rng_waddr] <= rng_wdata;
    end
    if (ctl.issue) begin
      ma_rng_q <= ma_rng[idx];
    end
  end

  // Match and accumulate
  logic [15:0] want;
  logic        gc_rec_hit;
  logic        ma_rec_hit;
  logic [3:0]  props;
  logic [3:0]  props_next;
  logic        mark_hit;
  logic        mark_hit_next;

  assign want = {8'h00, flag[15:8]};

  assign gc_rec_hit = rd_valid && (gc_format == gcsf_pkg::FMT_RANGE) &&
                      (32'(idx_d) < 32'(gc_rcount)) &&
                      (glyph >= gc_rng_q.first) && (glyph <= gc_rng_q.last);
  assign ma_rec_hit = rd_valid && (ma_format == gcsf_pkg::FMT_RANGE) &&
                      (32'(idx_d) < 32'(ma_rcount)) && (ma_rng_q.cls == want) &&
                      (glyph >= ma_rng_q.first) && (glyph <= ma_rng_q.last);

  always_comb begin
    props_next    = props;
    mark_hit_next = mark_hit;
    if (gc_rec_hit) begin
      props_next = props_next | gcsf_pkg::class_bits(gc_rng_q.cls);
    end
    if (ma_rec_hit) begin
      mark_hit_next = 1'b1;
    end
    if (ctl.dense_take) begin
      if (gc_format == gcsf_pkg::FMT_DENSE && gc_cover) begin
        props_next = props_next | gcsf_pkg::class_bits(gc_arr_q);
      end
      if (ma_format == gcsf_pkg::FMT_DENSE && ma_cover && ma_arr_q == want) begin
        mark_hit_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      props    <= '0;
      mark_hit <= 1'b0;
    end else begin
      props    <= props_next;
      mark_hit <= mark_hit_next;
    end
  end

  // Skip decision, in priority order
  logic skip;

  always_comb begin
    priority if (glyph == 16'd0) begin
      skip = 1'b1;
    end else if (flag[gcsf_pkg::FLAG_IGNORE_MARK] && props[gcsf_pkg::PROP_MARK]) begin
      skip = 1'b1;
    end else if (flag[gcsf_pkg::FLAG_IGNORE_LIG] && props[gcsf_pkg::PROP_LIG]) begin
      skip = 1'b1;
    end else if (flag[gcsf_pkg::FLAG_IGNORE_BASE] && props[gcsf_pkg::PROP_BASE]) begin
      skip = 1'b1;
    end else if ((flag[15:8] != 8'h00) && (ma_format != gcsf_pkg::FMT_NONE) &&
                 props[gcsf_pkg::PROP_MARK] && !mark_hit) begin
      skip = 1'b1;
    end else begin
      skip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      result.skipped      <= skip;
      result.is_base      <= props[gcsf_pkg::PROP_BASE];
      result.is_mark      <= props[gcsf_pkg::PROP_MARK];
      result.is_ligature  <= props[gcsf_pkg::PROP_LIG];
      result.is_component <= props[gcsf_pkg::PROP_COMP];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
    end
  end

  a_valid_follows_issue: assert property (@(posedge clk) disable iff (rst)
    ctl.issue |=> rd_valid)
    else $error("range read data not marked valid after issue");

  a_glyph_zero_skipped: assert property (@(posedge clk) disable iff (rst)
    (ctl.finish && glyph == 16'd0) |=> (done && result.skipped))
    else $error("glyph zero was not skipped");

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctl.finish))
    else $error("result strobe without a finish step");

endmodule
`default_nettype wire

// ===== sv/glyph_class_skip_filter_core.sv =====
// Top level of the glyph class skip filter: controller plus datapath.
// Query: accepted at start && !busy; the result word strobes on done after the
// 64-record range scan (one record per cycle from each range memory, both tables
// in parallel), the last-data step that takes the dense lookups, and the finish step.
// A new word may be accepted at the edge that ends the done cycle. Load commands
// leave the block idle and give no result. rst (synchronous) clears the configuration,
// the scan counter, done and the controller; table memories hold nothing until loaded.
`timescale 1ns / 1ps
`default_nettype none
module glyph_class_skip_filter_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire gcsf_pkg::gcsf_item_t  item,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [15:0]           cfg_data,
  output logic                       done,
  output gcsf_pkg::gcsf_result_t     result
);

  // Commands from the controller, status back from the datapath.
  gcsf_pkg::gcsf_cmd_t    ctl;
  gcsf_pkg::gcsf_status_t status;

  // Decode the word, step the scan and drive the finish pulse.
  gcsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd_code (item.cmd),
    .status   (status),
    .ctl      (ctl),
    .busy     (busy)
  );

  // Hold the tables and configuration; match records and decide the skip.
  gcsf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .ctl       (ctl),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .result    (result),
    .done      (done)
  );

  // The strobe falls in an idle cycle, so the next word can already be taken.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  // An accepted query holds the block busy in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == gcsf_pkg::CMD_QUERY) |=> busy)
    else $error("query accepted but block not busy");

  // A load never produces a result word.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd != gcsf_pkg::CMD_QUERY) |=> !done)
    else $error("load command produced a result");

endmodule
`default_nettype wire
